// File: rtl/hml_pkg.sv
// Package for the HTML markup lexer: transaction types, state codes,
// character constants and character-class helpers. No dependencies.
package hml_pkg;

  // Encoded lexer state as seen on the ports
  localparam logic [3:0] CODE_TEXT   = 4'd0;
  localparam logic [3:0] CODE_TAG0   = 4'd1;
  localparam logic [3:0] CODE_TAG    = 4'd2;
  localparam logic [3:0] CODE_EQL    = 4'd3;
  localparam logic [3:0] CODE_QUOTE  = 4'd4;
  localparam logic [3:0] CODE_DQUOTE = 4'd5;
  localparam logic [3:0] CODE_VALUE  = 4'd6;
  localparam logic [3:0] CODE_AMP    = 4'd7;
  localparam logic [3:0] CODE_CMNT1  = 4'd8;
  localparam logic [3:0] CODE_CMNT2  = 4'd9;
  localparam logic [3:0] CODE_CMNT   = 4'd10;
  localparam logic [3:0] CODE_NCMNT1 = 4'd11;
  localparam logic [3:0] CODE_NCMNT2 = 4'd12;
  localparam logic [3:0] CODE_NCMNT3 = 4'd13;
  localparam logic [3:0] CODE_IRRTAG = 4'd14;
  localparam logic [3:0] CODE_BAD    = 4'd15;

  // Command codes
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Characters
  localparam logic [7:0] CH_LT     = 8'h3C;  // <
  localparam logic [7:0] CH_AMP    = 8'h26;  // &
  localparam logic [7:0] CH_BANG   = 8'h21;  // !
  localparam logic [7:0] CH_GT     = 8'h3E;  // >
  localparam logic [7:0] CH_EQ     = 8'h3D;  // =
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [7:0] CH_HASH   = 8'h23;  // #
  localparam logic [7:0] CH_UNDER  = 8'h5F;  // _
  localparam logic [7:0] CH_DASH   = 8'h2D;  // -

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
    logic [3:0] load_value;
  } lex_item_t;

  typedef struct packed {
    logic [3:0] new_state;
    logic       is_text;
  } lex_result_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // ASCII digits and letters only
  function automatic logic is_letter_or_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// File: rtl/html_markup_lexer_fsm.sv
// HTML markup lexer top level: input register, next-state logic, result register.
// Depends on hml_pkg.
// A transaction passes through the input register and then the result register.
// Throughput: one byte per cycle unless the result stalls; the state register
// updates as each item leaves the input register, so consecutive bytes chain
// through it without a bubble. Reset (rst, synchronous, active high) empties
// both registers and returns the lexer to the text state.
module html_markup_lexer_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  hml_pkg::lex_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output hml_pkg::lex_result_t result
);
  import hml_pkg::*;

  // Lexer state, one-hot internally
  typedef enum logic [14:0] {
    S_TEXT   = 15'b000000000000001,
    S_TAG0   = 15'b000000000000010,
    S_TAG    = 15'b000000000000100,
    S_EQL    = 15'b000000000001000,
    S_QUOTE  = 15'b000000000010000,
    S_DQUOTE = 15'b000000000100000,
    S_VALUE  = 15'b000000001000000,
    S_AMP    = 15'b000000010000000,
    S_CMNT1  = 15'b000000100000000,
    S_CMNT2  = 15'b000001000000000,
    S_CMNT   = 15'b000010000000000,
    S_NCMNT1 = 15'b000100000000000,
    S_NCMNT2 = 15'b001000000000000,
    S_NCMNT3 = 15'b010000000000000,
    S_IRRTAG = 15'b100000000000000
  } lex_state_t;

  lex_state_t  lexer_state;
  lex_state_t  state_next;
  logic        text_next;
  logic [3:0]  code_next;

  logic        stage_valid;
  lex_item_t   stage;
  logic        advance;
  logic [7:0]  c;

  // The result register can take a new value when empty or being drained.
  assign advance    = !result_valid || !result_stall;
  // Hold the input register only while it is full and the result is blocked.
  assign item_stall = stage_valid && !advance;
  assign c          = stage.byte_in;

  // Next-state function for the byte held in the input register
  always_comb begin
    state_next = lexer_state;
    text_next  = 1'b0;
    if (stage.command == CMD_LOAD) begin
      // Load code fifteen means nothing: keep the current state.
      case (stage.load_value)
        CODE_TEXT:   state_next = S_TEXT;
        CODE_TAG0:   state_next = S_TAG0;
        CODE_TAG:    state_next = S_TAG;
        CODE_EQL:    state_next = S_EQL;
        CODE_QUOTE:  state_next = S_QUOTE;
        CODE_DQUOTE: state_next = S_DQUOTE;
        CODE_VALUE:  state_next = S_VALUE;
        CODE_AMP:    state_next = S_AMP;
        CODE_CMNT1:  state_next = S_CMNT1;
        CODE_CMNT2:  state_next = S_CMNT2;
        CODE_CMNT:   state_next = S_CMNT;
        CODE_NCMNT1: state_next = S_NCMNT1;
        CODE_NCMNT2: state_next = S_NCMNT2;
        CODE_NCMNT3: state_next = S_NCMNT3;
        CODE_IRRTAG: state_next = S_IRRTAG;
        default:     state_next = lexer_state;
      endcase
    end else begin
      case (lexer_state)
        S_TEXT: begin
          if (c == CH_LT) begin
            state_next = S_TAG0;
          end else begin
            // Entity start still counts as text.
            text_next  = 1'b1;
            state_next = (c == CH_AMP) ? S_AMP : S_TEXT;
          end
        end
        S_TAG0: begin
          if (c == CH_BANG)    state_next = S_CMNT1;
          else if (c == CH_GT) state_next = S_TEXT;
          else if (c == CH_EQ) state_next = S_EQL;
          else                 state_next = S_TAG;
        end
        S_TAG: begin
          if (c == CH_GT)      state_next = S_TEXT;
          else if (c == CH_EQ) state_next = S_EQL;
          else                 state_next = S_TAG;
        end
        S_EQL: begin
          if (c == CH_DQUOTE)      state_next = S_DQUOTE;
          else if (c == CH_SQUOTE) state_next = S_QUOTE;
          else if (is_ws(c))       state_next = S_EQL;
          else if (c == CH_GT)     state_next = S_TEXT;
          else                     state_next = S_VALUE;
        end
        S_QUOTE:  state_next = (c == CH_SQUOTE) ? S_TAG : S_QUOTE;
        S_DQUOTE: state_next = (c == CH_DQUOTE) ? S_TAG : S_DQUOTE;
        S_VALUE: begin
          if (c == CH_GT)    state_next = S_TEXT;
          else if (is_ws(c)) state_next = S_TAG;
          else               state_next = S_VALUE;
        end
        S_AMP: begin
          // Stay in the entity for name characters, leave on anything else.
          if (c == CH_SEMI)
            state_next = S_TEXT;
          else if (c != CH_HASH && c != CH_UNDER && !is_letter_or_digit(c))
            state_next = S_TEXT;
          else
            state_next = S_AMP;
        end
        S_CMNT1: begin
          if (c == CH_DASH)    state_next = S_CMNT2;
          else if (c == CH_GT) state_next = S_TEXT;
          else                 state_next = S_IRRTAG;
        end
        S_CMNT2: begin
          if (c == CH_DASH)    state_next = S_CMNT;
          else if (c == CH_GT) state_next = S_TEXT;
          else                 state_next = S_IRRTAG;
        end
        S_CMNT:   state_next = (c == CH_DASH) ? S_NCMNT1 : S_CMNT;
        S_NCMNT1: state_next = (c == CH_DASH) ? S_NCMNT2 : S_CMNT;
        S_NCMNT2: begin
          if (c == CH_GT)        state_next = S_TEXT;
          else if (c == CH_DASH) state_next = S_NCMNT2;
          else if (is_ws(c))     state_next = S_NCMNT3;
          else                   state_next = S_CMNT;
        end
        S_NCMNT3: begin
          if (c == CH_GT)        state_next = S_TEXT;
          else if (c == CH_DASH) state_next = S_NCMNT1;
          else if (is_ws(c))     state_next = S_NCMNT3;
          else                   state_next = S_CMNT;
        end
        S_IRRTAG: state_next = (c == CH_GT) ? S_TEXT : S_IRRTAG;
        default:  state_next = lexer_state;
      endcase
    end
  end

  // Encode the one-hot state for the result port
  always_comb begin
    case (state_next)
      S_TEXT:   code_next = CODE_TEXT;
      S_TAG0:   code_next = CODE_TAG0;
      S_TAG:    code_next = CODE_TAG;
      S_EQL:    code_next = CODE_EQL;
      S_QUOTE:  code_next = CODE_QUOTE;
      S_DQUOTE: code_next = CODE_DQUOTE;
      S_VALUE:  code_next = CODE_VALUE;
      S_AMP:    code_next = CODE_AMP;
      S_CMNT1:  code_next = CODE_CMNT1;
      S_CMNT2:  code_next = CODE_CMNT2;
      S_CMNT:   code_next = CODE_CMNT;
      S_NCMNT1: code_next = CODE_NCMNT1;
      S_NCMNT2: code_next = CODE_NCMNT2;
      S_NCMNT3: code_next = CODE_NCMNT3;
      S_IRRTAG: code_next = CODE_IRRTAG;
      default:  code_next = CODE_BAD;
    endcase
  end

  // Input register: capture a transaction whenever it is not held.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      stage <= item;
    end
  end

  // Result register and lexer state: advance together as an item moves out.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      lexer_state  <= S_TEXT;
    end else if (advance) begin
      result_valid <= stage_valid;
      if (stage_valid) begin
        lexer_state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      result.new_state <= code_next;
      result.is_text   <= text_next;
    end
  end

endmodule

// File: rtl/hml_checker.sv
// Port-level checks for the HTML markup lexer, bound to the top level.
// Depends on hml_pkg and html_markup_lexer_fsm.
module hml_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input hml_pkg::lex_result_t result
);
  import hml_pkg::*;

  // A blocked result stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Input backpressure only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // Text bytes leave the lexer in text or entity state.
  a_text_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_text |->
      result.new_state == CODE_TEXT || result.new_state == CODE_AMP)
    else $error("text flag in a markup state");

  // The undefined code never appears.
  a_no_bad: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.new_state != CODE_BAD)
    else $error("undefined lexer state reported");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind html_markup_lexer_fsm hml_checker u_hml_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: tb/lexer_checker.sv
// Checker for the HTML markup lexer: watches both channels, predicts each result
// with its own copy of the lexer state and compares. Depends on hml_pkg.
module lexer_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  hml_pkg::lex_item_t   item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  hml_pkg::lex_result_t result,
  output int                   errors,
  output int                   outstanding,
  output int                   checked,
  output logic [14:0]          states_seen
);
  import hml_pkg::*;

  logic [3:0]  lexer_now;
  lex_result_t expected_q[$];

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Body of a tag, shared by tag0 (after anything but '!') and tag.
  function automatic logic [3:0] tag_body_next(input logic [7:0] c);
    if (c == CH_GT) return CODE_TEXT;
    if (c == CH_EQ) return CODE_EQL;
    return CODE_TAG;
  endfunction

  function automatic logic [3:0] lexer_advance(input logic [3:0] s, input logic [7:0] c,
                                               output logic text);
    text = 1'b0;
    case (s)
      CODE_TEXT: begin
        if (c == CH_LT) return CODE_TAG0;
        text = 1'b1;
        return (c == CH_AMP) ? CODE_AMP : CODE_TEXT;
      end
      CODE_TAG0:   return (c == CH_BANG) ? CODE_CMNT1 : tag_body_next(c);
      CODE_TAG:    return tag_body_next(c);
      CODE_EQL: begin
        if (c == CH_DQUOTE) return CODE_DQUOTE;
        if (c == CH_SQUOTE) return CODE_QUOTE;
        if (is_blank(c)) return CODE_EQL;
        if (c == CH_GT) return CODE_TEXT;
        return CODE_VALUE;
      end
      CODE_QUOTE:  return (c == CH_SQUOTE) ? CODE_TAG : CODE_QUOTE;
      CODE_DQUOTE: return (c == CH_DQUOTE) ? CODE_TAG : CODE_DQUOTE;
      CODE_VALUE: begin
        if (c == CH_GT) return CODE_TEXT;
        return is_blank(c) ? CODE_TAG : CODE_VALUE;
      end
      CODE_AMP: begin
        if (c == CH_HASH || c == CH_UNDER || is_word_char(c)) return CODE_AMP;
        return CODE_TEXT;
      end
      CODE_CMNT1, CODE_CMNT2: begin
        if (c == CH_DASH) return (s == CODE_CMNT1) ? CODE_CMNT2 : CODE_CMNT;
        if (c == CH_GT) return CODE_TEXT;
        return CODE_IRRTAG;
      end
      CODE_CMNT:   return (c == CH_DASH) ? CODE_NCMNT1 : CODE_CMNT;
      CODE_NCMNT1: return (c == CH_DASH) ? CODE_NCMNT2 : CODE_CMNT;
      CODE_NCMNT2, CODE_NCMNT3: begin
        if (c == CH_GT) return CODE_TEXT;
        if (c == CH_DASH) return (s == CODE_NCMNT2) ? CODE_NCMNT2 : CODE_NCMNT1;
        return is_blank(c) ? CODE_NCMNT3 : CODE_CMNT;
      end
      CODE_IRRTAG: return (c == CH_GT) ? CODE_TEXT : CODE_IRRTAG;
      default:     return s;
    endcase
  endfunction

  always @(posedge clk) begin
    lex_result_t want;
    logic        text;
    if (rst) begin
      lexer_now = CODE_TEXT;
      expected_q.delete();
      errors = 0;
      checked = 0;
      states_seen = '0;
    end else begin
      // Retire first: a result can never belong to the transaction accepted at this edge.
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result state=%0d text=%0b", $time,
                   result.new_state, result.is_text);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (result.new_state <= CODE_IRRTAG) states_seen[result.new_state] = 1'b1;
          if (result.new_state !== want.new_state) begin
            errors++;
            $display("%0t: new_state expected %0d actual %0d", $time,
                     want.new_state, result.new_state);
          end
          if (result.is_text !== want.is_text) begin
            errors++;
            $display("%0t: is_text expected %0b actual %0b", $time,
                     want.is_text, result.is_text);
          end
        end
      end
      if (item_valid && !item_stall) begin
        text = 1'b0;
        if (item.command == CMD_LOAD) begin
          if (item.load_value <= CODE_IRRTAG) lexer_now = item.load_value;
        end else begin
          lexer_now = lexer_advance(lexer_now, item.byte_in, text);
        end
        want.new_state = lexer_now;
        want.is_text = text;
        expected_q.push_back(want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// File: tb/html_markup_lexer_fsm_test.sv
// Testbench top for the HTML markup lexer: clock, reset, byte stimulus and verdict.
// Depends on hml_pkg, html_markup_lexer_fsm and lexer_checker.
module html_markup_lexer_fsm_test;
  import hml_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  lex_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  lex_result_t result;

  int          errors;
  int          outstanding;
  int          checked;
  logic [14:0] states_seen;

  // Shared switch: while set, neither side idles, so back-to-back traffic gets exercised.
  logic        no_idle = 1'b0;
  int          sent = 0;
  int          loads = 0;

  always #5 clk = ~clk;

  html_markup_lexer_fsm u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  lexer_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked),
    .states_seen  (states_seen)
  );

  // Drive one transaction: idle for a random gap, present it at a falling edge and
  // hold it until a rising edge sees it accepted. Valid stays high across a zero gap.
  task automatic send_item(input lex_item_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= t;
    do @(posedge clk); while (item_stall);
    sent++;
    if (t.command == CMD_LOAD) loads++;
  endtask

  // Step with a byte; the unused load field carries random noise.
  task automatic put(input logic [7:0] c);
    lex_item_t t;
    t.command = CMD_STEP;
    t.byte_in = c;
    t.load_value = 4'($urandom_range(0, 15));
    send_item(t);
  endtask

  // Load the lexer state; the unused byte carries random noise.
  task automatic load_state(input logic [3:0] v);
    lex_item_t t;
    t.command = CMD_LOAD;
    t.byte_in = 8'($urandom_range(0, 255));
    t.load_value = v;
    send_item(t);
  endtask

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] v;
    v = 8'($urandom_range(8, 13));
    return (v == 8'd8) ? 8'h20 : v;
  endfunction

  // Markup characters and whitespace mixed with letters and arbitrary bytes.
  function automatic logic [7:0] rand_mixed();
    logic [7:0] marks [11];
    marks = '{CH_LT, CH_AMP, CH_BANG, CH_GT, CH_EQ, CH_DQUOTE, CH_SQUOTE,
              CH_SEMI, CH_HASH, CH_UNDER, CH_DASH};
    case ($urandom_range(0, 3))
      0:       return marks[4'($urandom_range(0, 10))];
      1:       return rand_blank();
      2:       return rand_alnum();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Plain text, sometimes with an entity reference that may or may not close.
  task automatic text_run();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) put(($urandom_range(0, 1) == 0) ? rand_alnum() : 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) begin
      put(CH_AMP);
      n = $urandom_range(0, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       put(CH_HASH);
          1:       put(CH_UNDER);
          default: put(rand_alnum());
        endcase
      end
      put(($urandom_range(0, 2) == 0) ? rand_mixed() : CH_SEMI);
    end
  endtask

  // Start tag with attributes in every quoting style.
  task automatic tag_run();
    int n;
    int attrs;
    put(CH_LT);
    n = $urandom_range(1, 4);
    repeat (n) put(rand_alnum());
    attrs = $urandom_range(0, 2);
    repeat (attrs) begin
      put(rand_blank());
      n = $urandom_range(1, 3);
      repeat (n) put(rand_alnum());
      put(CH_EQ);
      if ($urandom_range(0, 2) == 0) put(rand_blank());
      case ($urandom_range(0, 3))
        0: begin
          put(CH_DQUOTE);
          n = $urandom_range(0, 4);
          repeat (n) put(rand_mixed());
          put(CH_DQUOTE);
        end
        1: begin
          put(CH_SQUOTE);
          n = $urandom_range(0, 4);
          repeat (n) put(rand_mixed());
          put(CH_SQUOTE);
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) put(rand_alnum());
          if ($urandom_range(0, 1) == 0) put(rand_blank());
        end
        default: ;  // '=' with no value, followed by the next attribute or the closing '>'
      endcase
    end
    put(CH_GT);
  endtask

  // Comment with dashes and whitespace in the body and before the close.
  task automatic comment_run();
    int n;
    put(CH_LT);
    put(CH_BANG);
    put(CH_DASH);
    put(CH_DASH);
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0, 1:    put(CH_DASH);
        2:       put(rand_blank());
        3:       put(CH_GT);
        default: put(rand_mixed());
      endcase
    end
    put(CH_DASH);
    put(CH_DASH);
    n = $urandom_range(0, 2);
    repeat (n) put(rand_blank());
    if ($urandom_range(0, 3) == 0) put(CH_DASH);
    put(CH_GT);
  endtask

  // Declaration-like tag starting "<!", including the empty "<!>"; random content can still form a comment.
  task automatic irregular_run();
    int n;
    put(CH_LT);
    put(CH_BANG);
    if ($urandom_range(0, 2) == 0) put(CH_DASH);
    n = $urandom_range(0, 4);
    repeat (n) put(rand_mixed());
    put(CH_GT);
  endtask

  // Receiver: after each accepted result, stall for a random count of cycles.
  initial begin
    int hold;
    forever begin
      do @(posedge clk); while (!(result_valid && !result_stall));
      hold = no_idle ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [7:0] opening [25];
    int n;
    opening = '{8'h00, 8'hFF, CH_AMP, CH_HASH, CH_UNDER, "Z", CH_SEMI, CH_AMP, 8'h80,
                CH_LT, "p", CH_EQ, 8'h09, CH_DQUOTE, CH_GT, CH_DQUOTE, CH_EQ,
                CH_SQUOTE, CH_SQUOTE, CH_EQ, "v", 8'h0D, CH_EQ, CH_GT, CH_LT};

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, each attribute style, entity ends, loads incl. 15.
    foreach (opening[i]) put(opening[i]);
    load_state(CODE_BAD);      // ignored: stays in tag0
    put(CH_BANG);              // tag0 -> cmnt1
    load_state(CODE_IRRTAG);
    put(CH_GT);
    load_state(CODE_NCMNT2);
    put(8'h20);                // ncmnt2 -> ncmnt3 on whitespace

    // Random: mostly well-formed markup with random content, some noise and loads.
    while (sent < 1030) begin
      if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:     text_run();
        5, 6, 7, 8, 9:     tag_run();
        10, 11, 12, 13:    comment_run();
        14, 15:            irregular_run();
        16, 17: begin
          n = $urandom_range(1, 4);
          repeat (n) put(rand_mixed());
        end
        default:           load_state(4'($urandom_range(0, 15)));
      endcase
    end
    @(negedge clk);
    item_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then wait for any stray result to show up.
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    $display("Run covered %0d transactions (%0d state loads), %0d results compared,",
             sent, loads, checked);
    $display("lexer states reached (bit per state, irrtag leftmost): %015b", states_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog well above the slowest legal run.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: html_markup_lexer_fsm.f
rtl/hml_pkg.sv
rtl/html_markup_lexer_fsm.sv
rtl/hml_checker.sv
tb/lexer_checker.sv
tb/html_markup_lexer_fsm_test.sv
